### src/pkt_pkg.sv
package pkt_pkg;

	localparam int MAX_KEYS = 16;
	localparam int KEY_W    = 25;
	localparam int CODE_W   = 16;
	localparam int OP_W     = 3;
	localparam int MOD_W    = 4;
	localparam int HELD_W   = 5;
	localparam int IDX_W    = $clog2(MAX_KEYS);
	localparam int CNT_W    = $clog2(MAX_KEYS + 1);
	localparam int ENTRY_W  = KEY_W + CODE_W;

	localparam logic [KEY_W-1:0] SHIFT_KEY   = 25'h1000020;
	localparam logic [KEY_W-1:0] CONTROL_KEY = 25'h1000021;
	localparam logic [KEY_W-1:0] META_KEY    = 25'h1000022;
	localparam logic [KEY_W-1:0] ALT_KEY     = 25'h1000023;

	typedef enum logic [OP_W-1:0] {
		OP_PRESS   = 3'd0,
		OP_RELEASE = 3'd1,
		OP_QUERY   = 3'd2,
		OP_READ    = 3'd3,
		OP_CLEAR   = 3'd4
	} pkt_op_t;

	typedef enum logic [1:0] {
		INS_NONE   = 2'd0,
		INS_ALWAYS = 2'd1,
		INS_IFMISS = 2'd2
	} pkt_ins_t;

	// what the compare unit looks for
	typedef struct packed {
		logic [KEY_W-1:0]  key;
		logic [CODE_W-1:0] code;
	} pkt_target_t;

	// one sweep over the table
	typedef struct packed {
		pkt_target_t tgt;
		logic        remove;
		pkt_ins_t    ins_mode;
	} pkt_scan_t;

	// modifier bit order: shift, control, alt, meta
	function automatic logic [KEY_W-1:0] mod_key(input logic [1:0] idx);
		logic [KEY_W-1:0] k;
		case (idx)
			2'd0: k = SHIFT_KEY;
			2'd1: k = CONTROL_KEY;
			2'd2: k = ALT_KEY;
			default: k = META_KEY;
		endcase
		return k;
	endfunction

endpackage

### src/pressed_key_table.sv
// channel  direction  handshake                 payload
// command  in         start, busy               op, key_value, scan_code, auto_repeat,
//                                               modifier_bits, text_char, want_unicode
// result   out        done (one-cycle strobe)   is_held, held_count, last_value, dropped
//
// an item is taken at an edge with start high and busy low; one result per item follows
// a sweep compares one ram entry per cycle; an insert is written in the post state after it
// read last, clear all, auto-repeat and unused ops: no sweep, the item goes straight to the result state
// press, release and query: one sweep; press and release also sweep each modifier key when modifiers change
// reset clears the valid bits, count, latches and modifiers at once; no clearing pass
// the receiver cannot stall: done is high for exactly one cycle per item
module pressed_key_table import pkt_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  logic [OP_W-1:0]   op,
	input  logic [KEY_W-1:0]  key_value,
	input  logic [CODE_W-1:0] scan_code,
	input  logic              auto_repeat,
	input  logic [MOD_W-1:0]  modifier_bits,
	input  logic [CODE_W-1:0] text_char,
	input  logic              want_unicode,
	output logic              done,
	output logic              is_held,
	output logic [HELD_W-1:0] held_count,
	output logic [KEY_W-1:0]  last_value,
	output logic              dropped
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MODSET,
		ST_SCAN,
		ST_POST,
		ST_RESP
	} state_t;

	state_t             state_q;

	// item held for the whole operation
	pkt_op_t            op_q;
	logic [MOD_W-1:0]   mods_q;

	// table bookkeeping; keys and codes live in the ram
	logic [MAX_KEYS-1:0] entry_valid_q;
	logic [CNT_W-1:0]    count_q;
	logic [KEY_W-1:0]    latched_key_q;
	logic [CODE_W-1:0]   latched_char_q;
	logic [MOD_W-1:0]    prev_mods_q;

	// sweep control
	pkt_scan_t          scan_q;
	logic [IDX_W-1:0]   idx_q;
	logic               issue_q;
	logic               vld_s1;
	logic [IDX_W-1:0]   idx_s1;
	logic               hit_any_q;
	logic               found_free_q;
	logic [IDX_W-1:0]   free_idx_q;
	logic               mod_phase_q;
	logic [1:0]         mod_idx_q;

	// result registers
	logic               done_q;
	logic               res_held_q;
	logic [HELD_W-1:0]  res_count_q;
	logic [KEY_W-1:0]   res_last_q;
	logic               res_drop_q;

	// entry ram port signals
	logic               ram_wr_en;
	logic [ENTRY_W-1:0] ram_wr_data;
	logic [ENTRY_W-1:0] ram_rd_data;
	logic [KEY_W-1:0]   rd_key;
	logic [CODE_W-1:0]  rd_code;

	logic               hit;
	logic               remove_hit;
	logic               do_insert;
	logic               accept;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_KEYS - 1);

	assign accept = start && (state_q == ST_IDLE);
	assign busy   = (state_q != ST_IDLE);

	assign {rd_key, rd_code} = ram_rd_data;

	pkt_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_KEYS)
	) u_entries (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (free_idx_q),
		.wr_data (ram_wr_data),
		.rd_addr (idx_q),
		.rd_data (ram_rd_data)
	);

	// shared compare unit, one entry per cycle
	pkt_match u_match (
		.entry_valid (entry_valid_q[idx_s1]),
		.entry_key   (rd_key),
		.entry_code  (rd_code),
		.tgt         (scan_q.tgt),
		.hit         (hit)
	);

	assign remove_hit = vld_s1 && hit && scan_q.remove;

	assign do_insert = (scan_q.ins_mode == INS_ALWAYS) ||
		((scan_q.ins_mode == INS_IFMISS) && !hit_any_q);

	// insert goes to the first free slot found during the sweep
	assign ram_wr_en   = (state_q == ST_POST) && do_insert && found_free_q;
	assign ram_wr_data = {scan_q.tgt.key, scan_q.tgt.code};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			op_q           <= OP_PRESS;
			mods_q         <= '0;
			entry_valid_q  <= '0;
			count_q        <= '0;
			latched_key_q  <= '0;
			latched_char_q <= '0;
			prev_mods_q    <= '0;
			scan_q         <= '0;
			idx_q          <= '0;
			issue_q        <= 1'b0;
			vld_s1         <= 1'b0;
			idx_s1         <= '0;
			hit_any_q      <= 1'b0;
			found_free_q   <= 1'b0;
			free_idx_q     <= '0;
			mod_phase_q    <= 1'b0;
			mod_idx_q      <= '0;
			done_q         <= 1'b0;
			res_held_q     <= 1'b0;
			res_count_q    <= '0;
			res_last_q     <= '0;
			res_drop_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						op_q         <= pkt_op_t'(op);
						mods_q       <= modifier_bits;
						mod_phase_q  <= 1'b0;
						res_held_q   <= 1'b0;
						res_last_q   <= '0;
						res_drop_q   <= 1'b0;
						idx_q        <= '0;
						issue_q      <= 1'b1;
						vld_s1       <= 1'b0;
						hit_any_q    <= 1'b0;
						found_free_q <= 1'b0;
						state_q      <= ST_RESP;
						case (pkt_op_t'(op))
							OP_PRESS: begin
								latched_key_q  <= key_value;
								latched_char_q <= text_char;
								scan_q.tgt.key  <= key_value;
								scan_q.tgt.code <= scan_code;
								// coded press replaces, uncoded press only adds if absent
								scan_q.remove   <= (scan_code != '0);
								scan_q.ins_mode <= (scan_code != '0) ? INS_ALWAYS : INS_IFMISS;
								if (!auto_repeat) begin
									state_q <= ST_SCAN;
								end
							end
							OP_RELEASE: begin
								scan_q.tgt.key  <= key_value;
								scan_q.tgt.code <= scan_code;
								scan_q.remove   <= 1'b1;
								scan_q.ins_mode <= INS_NONE;
								if (!auto_repeat) begin
									state_q <= ST_SCAN;
								end
							end
							OP_QUERY: begin
								// code zeroed so the compare is on key value alone
								scan_q.tgt.key  <= key_value;
								scan_q.tgt.code <= '0;
								scan_q.remove   <= 1'b0;
								scan_q.ins_mode <= INS_NONE;
								state_q         <= ST_SCAN;
							end
							OP_READ: begin
								res_last_q     <= want_unicode ? KEY_W'(latched_char_q)
									: latched_key_q;
								latched_key_q  <= '0;
								latched_char_q <= '0;
							end
							OP_CLEAR: begin
								entry_valid_q  <= '0;
								count_q        <= '0;
								latched_key_q  <= '0;
								latched_char_q <= '0;
								prev_mods_q    <= '0;
							end
							default: begin
							end
						endcase
					end
				end

				ST_MODSET: begin
					// one sweep per modifier key, without a code
					scan_q.tgt.key  <= mod_key(mod_idx_q);
					scan_q.tgt.code <= '0;
					scan_q.remove   <= !mods_q[mod_idx_q];
					scan_q.ins_mode <= mods_q[mod_idx_q] ? INS_IFMISS : INS_NONE;
					idx_q           <= '0;
					issue_q         <= 1'b1;
					vld_s1          <= 1'b0;
					hit_any_q       <= 1'b0;
					found_free_q    <= 1'b0;
					state_q         <= ST_SCAN;
				end

				ST_SCAN: begin
					// address stage
					if (issue_q) begin
						idx_q <= idx_q + IDX_W'(1);
						if (idx_q == LAST_IDX) begin
							issue_q <= 1'b0;
						end
					end
					vld_s1 <= issue_q;
					idx_s1 <= idx_q;
					// compare stage on the entry just read
					if (vld_s1) begin
						if (hit) begin
							hit_any_q <= 1'b1;
						end
						if (remove_hit) begin
							entry_valid_q[idx_s1] <= 1'b0;
							count_q               <= count_q - CNT_W'(1);
						end
						if (!found_free_q && (!entry_valid_q[idx_s1] || remove_hit)) begin
							found_free_q <= 1'b1;
							free_idx_q   <= idx_s1;
						end
						if (idx_s1 == LAST_IDX) begin
							state_q <= ST_POST;
						end
					end
				end

				ST_POST: begin
					if (do_insert) begin
						if (found_free_q) begin
							entry_valid_q[free_idx_q] <= 1'b1;
							count_q                   <= count_q + CNT_W'(1);
						end else begin
							res_drop_q <= 1'b1;
						end
					end
					if (op_q == OP_QUERY) begin
						res_held_q <= hit_any_q;
					end
					state_q <= ST_RESP;
					if (!mod_phase_q) begin
						if ((op_q != OP_QUERY) && (mods_q != prev_mods_q)) begin
							prev_mods_q <= mods_q;
							mod_phase_q <= 1'b1;
							mod_idx_q   <= '0;
							state_q     <= ST_MODSET;
						end
					end else if (mod_idx_q != 2'd3) begin
						mod_idx_q <= mod_idx_q + 2'd1;
						state_q   <= ST_MODSET;
					end
				end

				ST_RESP: begin
					done_q      <= 1'b1;
					res_count_q <= HELD_W'(count_q);
					state_q     <= ST_IDLE;
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done       = done_q;
	assign is_held    = res_held_q;
	assign held_count = res_count_q;
	assign last_value = res_last_q;
	assign dropped    = res_drop_q;

	// result strobe never stays high back to back
	assert property (@(posedge clk) disable iff (!arst_n) done_q |=> !done_q)
		else $error("result strobe held for two cycles");

	// count never exceeds the table size
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(MAX_KEYS))
		else $error("held count above table size");

	// an insert never lands on a live entry
	assert property (@(posedge clk) disable iff (!arst_n)
		ram_wr_en |-> !entry_valid_q[free_idx_q])
		else $error("insert overwrites a valid entry");

	// an accepted item makes the block busy
	assert property (@(posedge clk) disable iff (!arst_n) accept |=> busy)
		else $error("item accepted without going busy");

	// the sweep ends only after its last entry was compared
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_POST) |-> ($past(vld_s1) && ($past(idx_s1) == LAST_IDX)))
		else $error("sweep ended early");

endmodule

### src/pkt_ram.sv
module pkt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data <= mem_q[rd_addr];
	end

endmodule

### src/pkt_match.sv
module pkt_match import pkt_pkg::*; (
	input  logic              entry_valid,
	input  logic [KEY_W-1:0]  entry_key,
	input  logic [CODE_W-1:0] entry_code,
	input  pkt_target_t       tgt,
	output logic              hit
);

	logic key_eq;
	logic code_eq;
	logic code_none;

	assign key_eq    = (entry_key == tgt.key);
	assign code_eq   = (entry_code == tgt.code);
	assign code_none = (entry_code == '0);

	// with a code: same code, or no code and same key; without: same key
	always_comb begin
		if (tgt.code != '0) begin
			hit = entry_valid && (code_eq || (code_none && key_eq));
		end else begin
			hit = entry_valid && key_eq;
		end
	end

endmodule
